FILE: src/rrts_pkg.sv
// ---------------------------------------------------------------------------
// rrts_pkg - shared types and constants for the round robin task scheduler
// Slot entry layout, slot states, operation and status codes, table size.
// ---------------------------------------------------------------------------
package rrts_pkg;

    // Table size and derived widths
    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int RCNT_W     = $clog2(SLOT_COUNT + 1);

    // Field widths of the transactions
    localparam int SP_W     = 32;
    localparam int LEN_W    = 32;
    localparam int OP_W     = 3;
    localparam int IDX_W    = 4;
    localparam int STATUS_W = 2;
    localparam int REAPED_W = 5;

    typedef enum logic [1:0] {
        ST_FREE     = 2'd0,
        ST_RUNNING  = 2'd1,
        ST_SLEEPING = 2'd2,
        ST_ZOMBIE   = 2'd3
    } slot_state_t;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 3'd0,
        OP_SWITCH = 3'd1,
        OP_SLEEP  = 3'd2,
        OP_KILL   = 3'd3,
        OP_REAP   = 3'd4,
        OP_CREATE = 3'd5
    } op_t;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_RUN  = 2'd2;

    // One slot of the task table
    typedef struct packed {
        slot_state_t         state;
        logic [SP_W-1:0]     sp;
        logic [LEN_W-1:0]    countdown;
    } slot_entry_t;

    // What the head unit saw in the slot it just processed
    typedef struct packed {
        logic created;
        logic reaped;
        logic running;
    } head_flags_t;

endpackage

FILE: src/rrts_cell.sv
// ---------------------------------------------------------------------------
// rrts_cell - one cell of the task table ring
// Holds one slot entry and takes its neighbor's entry on every shift.
// ---------------------------------------------------------------------------
module rrts_cell
    import rrts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        shift_en,
    input  logic        init_running,
    input  slot_entry_t entry_in,
    output slot_entry_t entry_out
);

    slot_entry_t entry_reg;

    // Hold the entry, or take the neighbor's entry on a shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg.state     <= init_running ? ST_RUNNING : ST_FREE;
            entry_reg.sp        <= '0;
            entry_reg.countdown <= '0;
        end
        else if (shift_en)
        begin
            entry_reg <= entry_in;
        end
    end

    assign entry_out = entry_reg;

endmodule

FILE: src/rrts_head.sv
// ---------------------------------------------------------------------------
// rrts_head - slot update unit at the head of the ring
// Applies the pending operation to the slot passing the head this cycle.
// ---------------------------------------------------------------------------
module rrts_head
    import rrts_pkg::*;
(
    input  slot_entry_t         entry_in,
    input  op_t                 op,
    input  logic [SLOT_W-1:0]   pos,
    input  logic [SLOT_W-1:0]   cur_slot,
    input  logic [SP_W-1:0]     sp_in,
    input  logic [LEN_W-1:0]    len_in,
    input  logic                enable,
    input  logic                create_done,
    output slot_entry_t         entry_out,
    output head_flags_t         flags
);

    logic                at_cur;
    logic [LEN_W-1:0]    cd_dec;

    assign at_cur = (pos == cur_slot);
    // Saturating countdown step
    assign cd_dec = (entry_in.countdown == '0) ? '0 : entry_in.countdown - 1'b1;

    // Update the slot according to the operation
    always_comb
    begin
        entry_out     = entry_in;
        flags.created = 1'b0;
        flags.reaped  = 1'b0;
        case (op)
            OP_TICK:
            begin
                if (entry_in.state == ST_SLEEPING)
                begin
                    entry_out.countdown = cd_dec;
                    if (cd_dec == '0)
                    begin
                        entry_out.state = ST_RUNNING;
                    end
                end
            end
            OP_SWITCH:
            begin
                if (enable && at_cur &&
                    (entry_in.state == ST_RUNNING || entry_in.state == ST_SLEEPING))
                begin
                    entry_out.sp = sp_in;
                end
            end
            OP_SLEEP:
            begin
                if (at_cur)
                begin
                    entry_out.countdown = len_in;
                    entry_out.state     = ST_SLEEPING;
                end
            end
            OP_KILL:
            begin
                if (at_cur)
                begin
                    entry_out.state = ST_ZOMBIE;
                end
            end
            OP_REAP:
            begin
                if (entry_in.state == ST_ZOMBIE)
                begin
                    entry_out.state = ST_FREE;
                    entry_out.sp    = '0;
                    flags.reaped    = 1'b1;
                end
            end
            OP_CREATE:
            begin
                if (!create_done && entry_in.state == ST_FREE)
                begin
                    entry_out.state = ST_RUNNING;
                    entry_out.sp    = sp_in;
                    flags.created   = 1'b1;
                end
            end
            default:
            begin
                entry_out = entry_in;
            end
        endcase
        flags.running = (entry_out.state == ST_RUNNING);
    end

endmodule

FILE: src/round_robin_task_table_scheduler_unit.sv
// ---------------------------------------------------------------------------
// round_robin_task_table_scheduler_unit - task table with round robin switch
// Slot entries circulate through a ring of cells; one head unit applies
// tick, switch, sleep, kill, reap and create to each slot as it passes.
// ---------------------------------------------------------------------------
//
//   channel   handshake              payload
//   --------  ---------------------  ------------------------------------------
//   input     in_valid / in_ready    operation, stack_pointer_in, sleep_length
//   output    out_valid / out_ready  stack_pointer_out, slot_index, status,
//                                    reaped_count
//   config    cfg_valid / cfg_ready  cfg_data (scheduler enable)
//
// Each operation rotates the ring of slot cells once around, so that every
// slot passes the head unit, then the result is loaded into the output register.
// The next transaction is accepted the cycle after that, even while the result
// still waits. If the result register is still full at the last step, the ring
// holds until it is taken. Reset restores the table at once: slot 0 running
// and current, all others free. cfg_ready is always high.
//
module round_robin_task_table_scheduler_unit
    import rrts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [OP_W-1:0]      operation,
    input  logic [SP_W-1:0]      stack_pointer_in,
    input  logic [LEN_W-1:0]     sleep_length,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [SP_W-1:0]      stack_pointer_out,
    output logic [IDX_W-1:0]     slot_index,
    output logic [STATUS_W-1:0]  status,
    output logic [REAPED_W-1:0]  reaped_count
);

    typedef enum logic {
        S_IDLE,
        S_WALK
    } state_t;

    state_t                state_reg;
    logic                  enable_reg;
    op_t                   op_reg;
    logic [SP_W-1:0]       sp_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [SLOT_W-1:0]     pos_reg;
    logic [SLOT_W-1:0]     cur_reg;

    // Walk accumulators
    logic                  create_found_reg, create_found_next;
    logic [SLOT_W-1:0]     create_idx_reg,   create_idx_next;
    logic [RCNT_W-1:0]     reap_cnt_reg,     reap_cnt_next;
    logic                  hi_found_reg,     hi_found_next;
    logic [SLOT_W-1:0]     hi_idx_reg,       hi_idx_next;
    logic [SP_W-1:0]       hi_sp_reg,        hi_sp_next;
    logic                  lo_found_reg,     lo_found_next;
    logic [SLOT_W-1:0]     lo_idx_reg,       lo_idx_next;
    logic [SP_W-1:0]       lo_sp_reg,        lo_sp_next;

    // Output register
    logic                  out_valid_reg;
    logic [SP_W-1:0]       sp_out_reg,   sp_out_next;
    logic [SLOT_W-1:0]     slot_out_reg, slot_out_next;
    logic [STATUS_W-1:0]   status_reg,   status_next;
    logic [RCNT_W-1:0]     reaped_reg;
    logic [SLOT_W-1:0]     cur_next;

    logic                  in_fire;
    logic                  out_fire;
    logic                  last_step;
    logic                  advance;
    logic                  finish;

    slot_entry_t           cell_q [SLOT_COUNT];
    slot_entry_t           head_entry;
    head_flags_t           head_flags;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign last_step = (pos_reg == SLOT_W'(SLOT_COUNT - 1));
    // Stall the last step while the result register is still occupied
    assign advance   = (state_reg == S_WALK) && (!last_step || !out_valid_reg || out_ready);
    assign finish    = advance && last_step;

    // Ring of cells: each takes its upper neighbor, the top takes the head result
    generate
        for (genvar i = 0; i < SLOT_COUNT; i++)
        begin : g_cell
            slot_entry_t cell_d;
            if (i == SLOT_COUNT - 1)
            begin : g_top
                assign cell_d = head_entry;
            end
            else
            begin : g_mid
                assign cell_d = cell_q[i + 1];
            end
            rrts_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .shift_en     (advance),
                .init_running (i == 0),
                .entry_in     (cell_d),
                .entry_out    (cell_q[i])
            );
        end
    endgenerate

    rrts_head u_head (
        .entry_in    (cell_q[0]),
        .op          (op_reg),
        .pos         (pos_reg),
        .cur_slot    (cur_reg),
        .sp_in       (sp_reg),
        .len_in      (len_reg),
        .enable      (enable_reg),
        .create_done (create_found_reg),
        .entry_out   (head_entry),
        .flags       (head_flags)
    );

    // Fold the slot at the head into the accumulators
    always_comb
    begin
        create_found_next = create_found_reg;
        create_idx_next   = create_idx_reg;
        reap_cnt_next     = reap_cnt_reg;
        hi_found_next     = hi_found_reg;
        hi_idx_next       = hi_idx_reg;
        hi_sp_next        = hi_sp_reg;
        lo_found_next     = lo_found_reg;
        lo_idx_next       = lo_idx_reg;
        lo_sp_next        = lo_sp_reg;
        if (head_flags.created)
        begin
            create_found_next = 1'b1;
            create_idx_next   = pos_reg;
        end
        if (head_flags.reaped)
        begin
            reap_cnt_next = reap_cnt_reg + 1'b1;
        end
        if (head_flags.running)
        begin
            if (pos_reg > cur_reg)
            begin
                if (!hi_found_reg)
                begin
                    hi_found_next = 1'b1;
                    hi_idx_next   = pos_reg;
                    hi_sp_next    = head_entry.sp;
                end
            end
            else if (!lo_found_reg)
            begin
                lo_found_next = 1'b1;
                lo_idx_next   = pos_reg;
                lo_sp_next    = head_entry.sp;
            end
        end
    end

    // Build the result and the next current slot
    always_comb
    begin
        sp_out_next   = '0;
        slot_out_next = '0;
        status_next   = STATUS_OK;
        cur_next      = cur_reg;
        case (op_reg)
            OP_SWITCH:
            begin
                if (!enable_reg)
                begin
                    sp_out_next   = sp_reg;
                    slot_out_next = cur_reg;
                end
                else if (hi_found_next)
                begin
                    sp_out_next   = hi_sp_next;
                    slot_out_next = hi_idx_next;
                    cur_next      = hi_idx_next;
                end
                else if (lo_found_next)
                begin
                    sp_out_next   = lo_sp_next;
                    slot_out_next = lo_idx_next;
                    cur_next      = lo_idx_next;
                end
                else
                begin
                    sp_out_next   = sp_reg;
                    slot_out_next = cur_reg;
                    status_next   = STATUS_NO_RUN;
                end
            end
            OP_CREATE:
            begin
                if (create_found_next)
                begin
                    slot_out_next = create_idx_next;
                end
                else
                begin
                    status_next = STATUS_NO_FREE;
                end
            end
            default:
            begin
                sp_out_next = '0;
            end
        endcase
    end

    // Sequencer, accumulators, configuration and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            enable_reg       <= 1'b0;
            op_reg           <= OP_TICK;
            sp_reg           <= '0;
            len_reg          <= '0;
            pos_reg          <= '0;
            cur_reg          <= '0;
            create_found_reg <= 1'b0;
            create_idx_reg   <= '0;
            reap_cnt_reg     <= '0;
            hi_found_reg     <= 1'b0;
            hi_idx_reg       <= '0;
            hi_sp_reg        <= '0;
            lo_found_reg     <= 1'b0;
            lo_idx_reg       <= '0;
            lo_sp_reg        <= '0;
            out_valid_reg    <= 1'b0;
            sp_out_reg       <= '0;
            slot_out_reg     <= '0;
            status_reg       <= STATUS_OK;
            reaped_reg       <= '0;
        end
        else
        begin
            // Take a configuration write
            if (cfg_valid && cfg_ready)
            begin
                enable_reg <= cfg_data;
            end

            // Load the result at the end of a walk, drop it once the transaction completes
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        op_reg           <= op_t'(operation);
                        sp_reg           <= stack_pointer_in;
                        len_reg          <= sleep_length;
                        pos_reg          <= '0;
                        create_found_reg <= 1'b0;
                        reap_cnt_reg     <= '0;
                        hi_found_reg     <= 1'b0;
                        lo_found_reg     <= 1'b0;
                        state_reg        <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    // Advance the head; the position wraps to zero after the last slot
                    if (advance)
                    begin
                        create_found_reg <= create_found_next;
                        create_idx_reg   <= create_idx_next;
                        reap_cnt_reg     <= reap_cnt_next;
                        hi_found_reg     <= hi_found_next;
                        hi_idx_reg       <= hi_idx_next;
                        hi_sp_reg        <= hi_sp_next;
                        lo_found_reg     <= lo_found_next;
                        lo_idx_reg       <= lo_idx_next;
                        lo_sp_reg        <= lo_sp_next;
                        pos_reg          <= pos_reg + 1'b1;
                    end
                    if (finish)
                    begin
                        cur_reg       <= cur_next;
                        sp_out_reg    <= sp_out_next;
                        slot_out_reg  <= slot_out_next;
                        status_reg    <= status_next;
                        reaped_reg    <= (op_reg == OP_REAP) ? reap_cnt_next : '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid         = out_valid_reg;
    assign stack_pointer_out = sp_out_reg;
    assign slot_index        = IDX_W'(slot_out_reg);
    assign status            = status_reg;
    assign reaped_count      = REAPED_W'(reaped_reg);

    // The head position steps by one on every advancing walk cycle
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !last_step) |=> (pos_reg == SLOT_W'($past(pos_reg) + 1'b1)))
        else $error("head position did not step");

    // The current slot always names a slot of the table
    a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg <= SLOT_W'(SLOT_COUNT - 1))
        else $error("current slot out of range");

    // A result appears only at the end of a full walk
    a_result_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(finish))
        else $error("result without a completed walk");

    // An accepted item starts a walk at the first slot
    a_accept_walk: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_WALK && pos_reg == '0))
        else $error("accepted item did not start a walk");

endmodule

FILE: tb/round_robin_task_table_scheduler_unit_tb.sv
// ---------------------------------------------------------------------------
// round_robin_task_table_scheduler_unit_tb - task table scheduler testbench
// A directed table walks reset behavior, every operation, the unused codes,
// the enable register and the full-table and nothing-runnable cases. Then
// about a thousand random operations follow, under three pacing mixes. A task
// table model predicts each reply the plan leaves open; each field is checked.
// ---------------------------------------------------------------------------
module round_robin_task_table_scheduler_unit_tb;
    import rrts_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ROW_COUNT   = 20;
    localparam int STALL_LEN   = 400;
    localparam int DRAIN_WAIT  = 40;

    // Operation codes the block treats as no-ops
    localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;
    localparam logic [SP_W-1:0] ONES        = '1;

    typedef struct packed {
        logic [SP_W-1:0]     sp;
        logic [IDX_W-1:0]    slot;
        logic [STATUS_W-1:0] status;
        logic [REAPED_W-1:0] reaped;
    } table_reply_t;

    // One line of the directed plan; reply is used only where known is set
    typedef struct packed {
        logic                set_cfg;
        logic                cfg_value;
        logic [OP_W-1:0]     op;
        logic [SP_W-1:0]     sp;
        logic [LEN_W-1:0]    len;
        logic [4:0]          reps;
        logic                known;
        table_reply_t        reply;
    } plan_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_data = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [OP_W-1:0]     operation = '0;
    logic [SP_W-1:0]     stack_pointer_in = '0;
    logic [LEN_W-1:0]    sleep_length = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [SP_W-1:0]     stack_pointer_out;
    logic [IDX_W-1:0]    slot_index;
    logic [STATUS_W-1:0] status;
    logic [REAPED_W-1:0] reaped_count;

    // Shadow copy of the task table
    slot_state_t         slot_st [SLOT_COUNT];
    logic [SP_W-1:0]     slot_sp [SLOT_COUNT];
    logic [LEN_W-1:0]    slot_cnt [SLOT_COUNT];
    logic [SLOT_W-1:0]   cur_slot;
    logic                sched_on;

    table_reply_t        pending_replies [$];
    table_reply_t        head_reply;
    plan_row_t           plan [ROW_COUNT];

    int                  send_idle_pct = 11;
    int                  recv_idle_pct = 55;
    logic                stall_pending = 1'b0;
    logic                stall_done = 1'b0;
    int                  hold_left = 0;
    int                  cycle_count = 0;
    int                  mismatch_count = 0;
    int                  items_sent = 0;
    int                  replies_seen = 0;
    int                  no_run_seen = 0;
    int                  no_free_seen = 0;
    int                  reaped_total = 0;

    round_robin_task_table_scheduler_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .operation         (operation),
        .stack_pointer_in  (stack_pointer_in),
        .sleep_length      (sleep_length),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .stack_pointer_out (stack_pointer_out),
        .slot_index        (slot_index),
        .status            (status),
        .reaped_count      (reaped_count)
    );

    // Clock: 10 high, 10 low
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d replies outstanding",
                   cycle_count, pending_replies.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Apply one operation to the shadow table and return the reply it gives
    task automatic apply_table_op(input logic [OP_W-1:0] op, input logic [SP_W-1:0] sp,
                                  input logic [LEN_W-1:0] len, output table_reply_t reply);
        logic [SLOT_W-1:0] nxt;
        logic              found;
        logic              placed;
        reply  = '0;
        found  = 1'b0;
        placed = 1'b0;
        case (op)
            OP_TICK:
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (slot_st[i] == ST_SLEEPING)
                    begin
                        if (slot_cnt[i] != 0)
                            slot_cnt[i] = slot_cnt[i] - 1'b1;
                        if (slot_cnt[i] == 0)
                            slot_st[i] = ST_RUNNING;
                    end
                end
            end
            OP_SWITCH:
            begin
                if (!sched_on)
                begin
                    reply.sp   = sp;
                    reply.slot = IDX_W'(cur_slot);
                end
                else
                begin
                    if (slot_st[cur_slot] == ST_RUNNING || slot_st[cur_slot] == ST_SLEEPING)
                        slot_sp[cur_slot] = sp;
                    // Search every slot once, ending at the current one
                    nxt = cur_slot;
                    for (int i = 0; i < SLOT_COUNT && !found; i++)
                    begin
                        nxt = (nxt == SLOT_W'(SLOT_COUNT - 1)) ? '0 : nxt + 1'b1;
                        if (slot_st[nxt] == ST_RUNNING)
                            found = 1'b1;
                    end
                    if (found)
                    begin
                        cur_slot = nxt;
                        reply.sp = slot_sp[cur_slot];
                    end
                    else
                    begin
                        reply.sp     = sp;
                        reply.status = STATUS_NO_RUN;
                    end
                    reply.slot = IDX_W'(cur_slot);
                end
            end
            OP_SLEEP:
            begin
                slot_cnt[cur_slot] = len;
                slot_st[cur_slot]  = ST_SLEEPING;
            end
            OP_KILL:
                slot_st[cur_slot] = ST_ZOMBIE;
            OP_REAP:
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (slot_st[i] == ST_ZOMBIE)
                    begin
                        slot_st[i]   = ST_FREE;
                        slot_sp[i]   = '0;
                        reply.reaped = reply.reaped + 1'b1;
                    end
                end
            end
            OP_CREATE:
            begin
                reply.status = STATUS_NO_FREE;
                for (int i = 0; i < SLOT_COUNT && !placed; i++)
                begin
                    if (slot_st[i] == ST_FREE)
                    begin
                        slot_sp[i]   = sp;
                        slot_st[i]   = ST_RUNNING;
                        reply.slot   = IDX_W'(i);
                        reply.status = STATUS_OK;
                        placed       = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Offer one operation, hold it until taken, then queue its reply
    task automatic send_item(input logic [OP_W-1:0] op, input logic [SP_W-1:0] sp,
                             input logic [LEN_W-1:0] len, input logic known,
                             input table_reply_t typed);
        table_reply_t reply;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid         <= 1'b1;
        operation        <= op;
        stack_pointer_in <= sp;
        sleep_length     <= len;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_table_op(op, sp, len, reply);
        pending_replies.push_back(known ? typed : reply);
        items_sent++;
    endtask

    // Drop valid and wait until every reply is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_enable(input logic value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sched_on = value;
    endtask

    // Mostly create, switch and tick, with short sleeps so sleepers wake again
    task automatic run_random_ops(input int count);
        logic [OP_W-1:0]  op;
        logic [LEN_W-1:0] len;
        int               pick;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 18)
                op = OP_TICK;
            else if (pick < 46)
                op = OP_SWITCH;
            else if (pick < 56)
                op = OP_SLEEP;
            else if (pick < 63)
                op = OP_KILL;
            else if (pick < 70)
                op = OP_REAP;
            else if (pick < 94)
                op = OP_CREATE;
            else
                op = $urandom_range(1) ? OP_UNUSED_7 : OP_UNUSED_6;
            pick = $urandom_range(99);
            if (pick < 70)
                len = $urandom_range(4);
            else if (pick < 97)
                len = $urandom_range(40);
            else
                len = $urandom();
            send_item(op, $urandom(), len, 1'b0, '0);
        end
    endtask

    // Result side: check each transaction, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_replies.size() == 0)
                begin
                    $error("reply transaction with no operation outstanding");
                    mismatch_count++;
                end
                else
                begin
                    head_reply = pending_replies.pop_front();
                    replies_seen++;
                    if (status == STATUS_NO_RUN)
                        no_run_seen++;
                    if (status == STATUS_NO_FREE)
                        no_free_seen++;
                    reaped_total += reaped_count;
                    if (stack_pointer_out !== head_reply.sp)
                    begin
                        $error("stack_pointer_out: expected %h, actual %h",
                               head_reply.sp, stack_pointer_out);
                        mismatch_count++;
                    end
                    if (slot_index !== head_reply.slot)
                    begin
                        $error("slot_index: expected %0d, actual %0d",
                               head_reply.slot, slot_index);
                        mismatch_count++;
                    end
                    if (status !== head_reply.status)
                    begin
                        $error("status: expected %0d, actual %0d", head_reply.status, status);
                        mismatch_count++;
                    end
                    if (reaped_count !== head_reply.reaped)
                    begin
                        $error("reaped_count: expected %0d, actual %0d",
                               head_reply.reaped, reaped_count);
                        mismatch_count++;
                    end
                end
            end
            // Hold off once for a long stretch so the block backs up its input
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (stall_pending && !stall_done)
            begin
                out_ready  <= 1'b0;
                hold_left  <= STALL_LEN;
                stall_done <= 1'b1;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        // Shadow table after reset
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            slot_st[i]  = ST_FREE;
            slot_sp[i]  = '0;
            slot_cnt[i] = '0;
        end
        slot_st[0] = ST_RUNNING;
        cur_slot   = '0;
        sched_on   = 1'b0;

        // set_cfg, value, op, sp, len, reps, known, reply
        plan = '{
            '{0, 0, OP_SWITCH,   ONES,          0,    1, 1, '{ONES, 0, STATUS_OK, 0}},
            '{0, 0, OP_UNUSED_7, ONES,          ONES, 1, 1, '0},
            '{0, 0, OP_TICK,     0,             0,    1, 1, '0},
            '{1, 1, OP_SLEEP,    0,             0,    1, 1, '0},
            '{0, 0, OP_SWITCH,   32'hCAFE_F00D, 0,    1, 1,
              '{32'hCAFE_F00D, 0, STATUS_NO_RUN, 0}},
            '{0, 0, OP_TICK,     0,             0,    1, 1, '0},
            '{0, 0, OP_SWITCH,   32'h1234_5678, 0,    1, 0, '0},
            '{0, 0, OP_SLEEP,    0,             1,    1, 1, '0},
            '{0, 0, OP_SWITCH,   0,             0,    1, 1, '{0, 0, STATUS_NO_RUN, 0}},
            '{0, 0, OP_TICK,     0,             0,    1, 1, '0},
            '{0, 0, OP_KILL,     0,             0,    1, 1, '0},
            '{0, 0, OP_SWITCH,   ONES,          0,    1, 1, '{ONES, 0, STATUS_NO_RUN, 0}},
            '{0, 0, OP_CREATE,   32'h8000_0000, 0,   15, 0, '0},
            '{0, 0, OP_CREATE,   ONES,          0,    1, 1, '{0, 0, STATUS_NO_FREE, 0}},
            '{0, 0, OP_REAP,     0,             0,    1, 1, '{0, 0, STATUS_OK, 1}},
            '{0, 0, OP_SWITCH,   32'h5555_5555, 0,    1, 0, '0},
            '{0, 0, OP_SLEEP,    0,             ONES, 1, 1, '0},
            '{0, 0, OP_SWITCH,   32'hAAAA_AAAA, 0,    1, 0, '0},
            '{1, 0, OP_SWITCH,   32'h0F0F_0F0F, 0,    1, 0, '0},
            '{0, 0, OP_UNUSED_6, 0,             0,    1, 1, '0}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed plan, sender idles lightly and receiver heavily
        foreach (plan[r])
        begin
            if (plan[r].set_cfg)
            begin
                wait_drained();
                write_enable(plan[r].cfg_value);
            end
            for (int k = 0; k < plan[r].reps; k++)
                send_item(plan[r].op, SP_W'(plan[r].sp + k), plan[r].len,
                          plan[r].known, plan[r].reply);
        end

        // Scheduler on, one long receiver stall
        wait_drained();
        write_enable(1'b1);
        stall_pending = 1'b1;
        run_random_ops(420);

        // Scheduler off, pacing swapped
        wait_drained();
        write_enable(1'b0);
        send_idle_pct = 55;
        recv_idle_pct = 11;
        run_random_ops(180);

        // Scheduler on, back to back
        wait_drained();
        write_enable(1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_ops(420);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);

        if (pending_replies.size() != 0)
        begin
            $error("%0d replies never arrived", pending_replies.size());
            mismatch_count++;
        end
        $display("Run: %0d operations sent, %0d replies compared, scheduler on and off.",
                 items_sent, replies_seen);
        $display("Seen: %0d switches with nothing runnable, %0d creates on a full table, %0d reaped.",
                 no_run_seen, no_free_seen, reaped_total);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
